// File: rtl/core/bpa_pkg.sv
`default_nettype none
package bpa_pkg;
	localparam int NUM_PAGES   = 65536;
	localparam int PAGE_BYTES  = 4096;
	localparam int MAX_RUN     = 1024;
	localparam int WORD_BITS   = 64;
	localparam int CHUNK_BITS  = 8;
	localparam int MAP_WORDS   = NUM_PAGES / WORD_BITS;
	localparam int PAGE_W      = $clog2(NUM_PAGES);
	localparam int LIMIT_W     = PAGE_W + 1;
	localparam int WADDR_W     = $clog2(MAP_WORDS);
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int CHUNK_W     = $clog2(WORD_BITS / CHUNK_BITS);
	localparam int CSEL_W      = $clog2(CHUNK_BITS);
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int COUNT_W     = 17;
	localparam int N_W         = 11;
	localparam int ADDR_W      = 64;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESERVE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BAD     = 2'd2
	} status_t;

	localparam logic REG_MANAGED = 1'b0;
	localparam logic REG_OFFSET  = 1'b1;

	typedef struct packed {
		logic               found;
		logic [PAGE_W-1:0]  end_page;
		logic [N_W-1:0]     run;
	} scan_res_t;
endpackage
`default_nettype wire

// File: rtl/core/bitmap_page_allocator_unit.sv
// First-fit page allocator over a 64K-page used map (1024 x 64-bit RAM). Pulse start
// while busy is low; the single result appears on address_res/status/allocated_pages
// with done, which is high for one cycle and cannot be stalled, so capture it then. After
// reset the map is cleared, one word a cycle, while busy stays high. Allocate scans 8
// pages a cycle from page 0, then marks the run by read-modify-write of each map word
// touched (up to 17 words). Free clears and reserve sets its run the same way.
`default_nettype none
module bitmap_page_allocator_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  opcode,
	input  wire logic [bpa_pkg::N_W-1:0]     page_count,
	input  wire logic [bpa_pkg::ADDR_W-1:0]  address,
	output logic                             done,
	output logic [bpa_pkg::ADDR_W-1:0]       address_res,
	output logic [1:0]                       status,
	output logic [bpa_pkg::COUNT_W-1:0]      allocated_pages,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [bpa_pkg::ADDR_W-1:0]  cfg_data
);
	import bpa_pkg::*;

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_DEC, S_SCAN, S_RD, S_WR} state_t;

	state_t                 state_q;
	logic [LIMIT_W-1:0]     managed_q;
	logic [ADDR_W-1:0]      offset_q;
	logic [COUNT_W-1:0]     count_q;
	op_t                    op_q;
	logic [N_W-1:0]         n_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [LIMIT_W-1:0]     base_q;
	logic [N_W-1:0]         run_q;
	logic [WORD_BITS-1:0]   word_q;
	logic [PAGE_W-1:0]      lo_q, hi_q;
	logic [WADDR_W-1:0]     wptr_q;
	logic                   set_q;

	logic                   mem_we, mem_re;
	logic [WADDR_W-1:0]     mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0]   mem_wdata, mem_rdata;

	logic [LIMIT_W-1:0]     limit;
	logic [CHUNK_W-1:0]     chunk;
	logic [WORD_BITS-1:0]   cur_word;
	logic [CHUNK_BITS-1:0]  chunk_bits;
	scan_res_t              sres;
	logic [ADDR_W-1:0]      diff;
	logic [ADDR_W-PAGE_SHIFT-1:0] start_pg;
	logic [ADDR_W-PAGE_SHIFT:0]   start_end;
	logic                   range_bad;
	logic [BIT_W-1:0]       lo_b, hi_b;
	logic [WORD_BITS-1:0]   mask;
	logic [COUNT_W:0]       count_sum;
	logic [LIMIT_W-1:0]     lo_ext;

	assign busy            = (state_q != S_IDLE);
	assign allocated_pages = count_q;
	assign limit = (managed_q > LIMIT_W'(NUM_PAGES)) ? LIMIT_W'(NUM_PAGES) : managed_q;

	assign chunk      = base_q[BIT_W-1:CSEL_W];
	assign cur_word   = (chunk == '0) ? mem_rdata : word_q;
	assign chunk_bits = CHUNK_BITS'(cur_word >> {chunk, CSEL_W'(0)});

	bpa_scan u_scan (
		.used   (chunk_bits),
		.base   (base_q),
		.limit  (limit),
		.count  (n_q),
		.run_in (run_q),
		.res    (sres)
	);

	assign diff      = addr_q - offset_q;
	assign start_pg  = diff[ADDR_W-1:PAGE_SHIFT];
	assign start_end = {1'b0, start_pg} + (ADDR_W-PAGE_SHIFT+1)'(n_q);
	assign range_bad = (start_pg > (ADDR_W-PAGE_SHIFT)'(NUM_PAGES))
		|| (start_end > (ADDR_W-PAGE_SHIFT+1)'(NUM_PAGES));

	assign lo_b = (wptr_q == lo_q[PAGE_W-1:BIT_W]) ? lo_q[BIT_W-1:0] : '0;
	assign hi_b = (wptr_q == hi_q[PAGE_W-1:BIT_W]) ? hi_q[BIT_W-1:0] : '1;
	assign mask = ({WORD_BITS{1'b1}} << lo_b) & ({WORD_BITS{1'b1}} >> (~hi_b));

	assign count_sum = {1'b0, count_q} + (COUNT_W+1)'(n_q);
	assign lo_ext    = LIMIT_W'(sres.end_page) + LIMIT_W'(1) - LIMIT_W'(n_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wptr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = wptr_q;
		unique case (state_q)
			S_CLR: mem_we = 1'b1;
			S_DEC: begin
				mem_re    = 1'b1;
				mem_raddr = '0;
			end
			S_SCAN: begin
				mem_re    = (chunk == '1);
				mem_raddr = base_q[PAGE_W-1:BIT_W] + WADDR_W'(1);
			end
			S_RD: mem_re = 1'b1;
			S_WR: begin
				mem_we    = 1'b1;
				mem_wdata = set_q ? (mem_rdata | mask) : (mem_rdata & ~mask);
			end
			default: ;
		endcase
	end

	bpa_ram #(.DEPTH(MAP_WORDS), .WIDTH(WORD_BITS)) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			managed_q   <= LIMIT_W'(NUM_PAGES);
			offset_q    <= '0;
			count_q     <= '0;
			wptr_q      <= '0;
			done        <= 1'b0;
			status      <= ST_OK;
			address_res <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MANAGED)
					managed_q <= cfg_data[LIMIT_W-1:0];
				else
					offset_q <= cfg_data;
			end
			unique case (state_q)
				S_CLR: begin
					done   <= 1'b0;
					wptr_q <= wptr_q + WADDR_W'(1);
					if (wptr_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					done <= 1'b0;
					if (start) begin
						op_q    <= op_t'(opcode);
						n_q     <= page_count;
						addr_q  <= address;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					base_q <= '0;
					run_q  <= '0;
					if (op_q == OP_NONE || n_q == '0 || n_q > N_W'(MAX_RUN)) begin
						status      <= ST_BAD;
						address_res <= '0;
						done        <= 1'b1;
						state_q     <= S_IDLE;
					end else if (op_q == OP_ALLOC) begin
						if (limit == '0) begin
							status      <= ST_NOSPACE;
							address_res <= '0;
							done        <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							done    <= 1'b0;
							state_q <= S_SCAN;
						end
					end else if (range_bad) begin
						status      <= ST_BAD;
						address_res <= '0;
						done        <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						done    <= 1'b0;
						lo_q    <= start_pg[PAGE_W-1:0];
						hi_q    <= PAGE_W'(start_end - (ADDR_W-PAGE_SHIFT+1)'(1));
						wptr_q  <= start_pg[PAGE_W-1:BIT_W];
						set_q   <= (op_q == OP_RESERVE);
						state_q <= S_RD;
					end
				end
				S_SCAN: begin
					if (chunk == '0)
						word_q <= mem_rdata;
					if (sres.found) begin
						done    <= 1'b0;
						lo_q    <= lo_ext[PAGE_W-1:0];
						hi_q    <= sres.end_page;
						wptr_q  <= lo_ext[PAGE_W-1:BIT_W];
						set_q   <= 1'b1;
						state_q <= S_RD;
					end else if (base_q + LIMIT_W'(CHUNK_BITS) >= limit) begin
						status      <= ST_NOSPACE;
						address_res <= '0;
						done        <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						done   <= 1'b0;
						base_q <= base_q + LIMIT_W'(CHUNK_BITS);
						run_q  <= sres.run;
					end
				end
				S_RD: begin
					done    <= 1'b0;
					state_q <= S_WR;
				end
				S_WR: begin
					if (wptr_q == hi_q[PAGE_W-1:BIT_W]) begin
						status  <= ST_OK;
						done    <= 1'b1;
						state_q <= S_IDLE;
						unique case (op_q)
							OP_ALLOC: begin
								count_q <= (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
									: count_sum[COUNT_W-1:0];
								address_res <= (ADDR_W'(lo_q) << PAGE_SHIFT) + offset_q;
							end
							OP_FREE: begin
								count_q <= (count_q > COUNT_W'(n_q))
									? count_q - COUNT_W'(n_q) : '0;
								address_res <= '0;
							end
							default: address_res <= '0;
						endcase
					end else begin
						done    <= 1'b0;
						wptr_q  <= wptr_q + WADDR_W'(1);
						state_q <= S_RD;
					end
				end
				default: begin
					done    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/bpa_ram.sv
`default_nettype none
module bpa_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/core/bpa_scan.sv
`default_nettype none
module bpa_scan (
	input  wire logic [bpa_pkg::CHUNK_BITS-1:0] used,
	input  wire logic [bpa_pkg::LIMIT_W-1:0]    base,
	input  wire logic [bpa_pkg::LIMIT_W-1:0]    limit,
	input  wire logic [bpa_pkg::N_W-1:0]        count,
	input  wire logic [bpa_pkg::N_W-1:0]        run_in,
	output bpa_pkg::scan_res_t                  res
);
	import bpa_pkg::*;

	// run length walks across one chunk; stops at the first page that completes the run
	always_comb begin
		logic [LIMIT_W-1:0] pg;
		res.found    = 1'b0;
		res.end_page = '0;
		res.run      = run_in;
		for (int j = 0; j < CHUNK_BITS; j++) begin
			pg = base + LIMIT_W'(j);
			if (!res.found && pg < limit) begin
				if (used[j]) begin
					res.run = '0;
				end else begin
					res.run = res.run + N_W'(1);
					if (res.run == count) begin
						res.found    = 1'b1;
						res.end_page = pg[PAGE_W-1:0];
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/bpa_checker.sv
`default_nettype none
module bpa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [63:0] address_res
);
	import bpa_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("transfer did not start work");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_BAD) else $error("bad status code");
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> address_res == '0) else $error("address on failure");
endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.address_res (address_res)
);
`default_nettype wire
